// ===== sv/int8_quadratic_form_eval_defines.svh =====
// Assertion macros shared by the quadratic form evaluator.
`ifndef INT8_QUADRATIC_FORM_EVAL_DEFINES_SVH
`define INT8_QUADRATIC_FORM_EVAL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QFE_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QFE_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qfe_pkg.sv =====
// Shared constants, types and helper functions of the quadratic form evaluator.
`default_nettype none

package qfe_pkg;

	// Matrix dimension.
	localparam int QFE_DIM = 32;

	// Field widths of one input beat and one result beat.
	localparam int ROW_W      = 5;
	localparam int COL_W      = 5;
	localparam int WEIGHT_W   = 8;
	localparam int LEVEL_W    = 8;
	localparam int VALUE_W    = 18;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	// Accumulator word width and the number of words in one summing group.
	localparam int WORD_W = 16;
	localparam int GROUP  = 4;

	// Request kinds carried on tuser.
	localparam logic REQ_WEIGHT = 1'b0;
	localparam logic REQ_LEVEL  = 1'b1;

	// Saturation bounds of the pair sum.
	localparam logic signed [17:0] SAT_MAX = 18'sd32767;
	localparam logic signed [17:0] SAT_MIN = -18'sd32768;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             clear_acc;
		logic             issue;
		logic [ROW_W-1:0] row_idx;
		logic             group_load;
		logic             total_load;
	} qfe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic out_free;
	} qfe_stat_t;

	// Clamp an 18-bit pair sum to the signed 16-bit range.
	function automatic logic [WORD_W-1:0] sat16(input logic signed [17:0] x);
		logic [WORD_W-1:0] r;
		if (x > SAT_MAX) begin
			r = 16'h7FFF;
		end else if (x < SAT_MIN) begin
			r = 16'h8000;
		end else begin
			r = x[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/qfe_ctrl.sv =====
// Controller state machine that sequences loading, the row walk and the final sums.
`default_nettype none

module qfe_ctrl #(
	parameter int DIM = qfe_pkg::QFE_DIM
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              in_eval,
	input  wire qfe_pkg::qfe_stat_t stat,
	output qfe_pkg::qfe_cmd_t      cmd,
	output logic                   in_ready
);
	import qfe_pkg::*;

	localparam int IW = $clog2(DIM);
	localparam logic [IW-1:0] LAST_ROW = IW'(DIM - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_GROUP = 3'd3;
	localparam logic [2:0] ST_TOTAL = 3'd4;

	logic [2:0]    state_q, state_n;
	logic [IW-1:0] row_q, row_n;

	// State and row counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_n;
			row_q   <= row_n;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_n        = state_q;
		row_n          = row_q;
		in_ready       = 1'b0;
		cmd.clear_acc  = 1'b0;
		cmd.issue      = 1'b0;
		cmd.row_idx    = ROW_W'(row_q);
		cmd.group_load = 1'b0;
		cmd.total_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire && in_eval) begin
					cmd.clear_acc = 1'b1;
					row_n         = '0;
					state_n       = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (row_q == LAST_ROW) begin
					state_n = ST_DRAIN;
				end else begin
					row_n = row_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_n = ST_GROUP;
				end
			end
			ST_GROUP: begin
				cmd.group_load = 1'b1;
				state_n        = ST_TOTAL;
			end
			ST_TOTAL: begin
				// Hold until the result register is free to take a new value.
				if (stat.out_free) begin
					cmd.total_load = 1'b1;
					state_n        = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/qfe_dpath.sv =====
// Datapath: weight memory, level registers, multiply lanes, accumulators and result register.
`default_nettype none

module qfe_dpath #(
	parameter int DIM = qfe_pkg::QFE_DIM
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic                          wr_type,
	input  wire logic [qfe_pkg::ROW_W-1:0]     wr_row,
	input  wire logic [qfe_pkg::COL_W-1:0]     wr_col,
	input  wire logic signed [qfe_pkg::WEIGHT_W-1:0] wr_weight,
	input  wire logic [qfe_pkg::LEVEL_W-1:0]   wr_level,
	input  wire qfe_pkg::qfe_cmd_t             cmd,
	output qfe_pkg::qfe_stat_t                 stat,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic signed [qfe_pkg::VALUE_W-1:0] out_value
);
	import qfe_pkg::*;

	localparam int IW       = $clog2(DIM);
	localparam int WORDS    = DIM / 2;
	localparam int NGRP     = WORDS / GROUP;
	localparam int ROW_BITS = DIM * WEIGHT_W;
	localparam int PROD_W   = WEIGHT_W + LEVEL_W + 1;
	localparam int MUL_W    = WORD_W + LEVEL_W;

	// Weight memory: one row of the matrix per entry, byte-wide writes.
	logic [ROW_BITS-1:0] wmem [DIM];
	logic [ROW_BITS-1:0] wrow_s1;

	// Level registers and pipeline payload.
	logic [LEVEL_W-1:0]       lvl_q [DIM];
	logic [LEVEL_W-1:0]       vi_s1, vi_s2;
	logic signed [PROD_W-1:0] prod_s2 [DIM];
	logic [WORD_W-1:0]        term_s3 [WORDS];
	logic [WORD_W-1:0]        acc_q [WORDS];
	logic [WORD_W-1:0]        grp_q [NGRP];
	logic                     valid_s1, valid_s2, valid_s3;
	logic                     out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;

	logic signed [PROD_W:0]   pair_sum [WORDS];
	logic [MUL_W-1:0]         mul_full [WORDS];
	logic [WORD_W-1:0]        grp_sum [NGRP];
	logic signed [VALUE_W-1:0] total;

	// Memory write port and registered row read.
	always_ff @(posedge clk) begin
		if (wr_en && wr_type == REQ_WEIGHT) begin
			wmem[wr_row[IW-1:0]][wr_col[IW-1:0]*WEIGHT_W +: WEIGHT_W] <= wr_weight;
		end
		if (cmd.issue) begin
			wrow_s1 <= wmem[cmd.row_idx[IW-1:0]];
		end
	end

	// Level registers, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIM; k++) begin
				lvl_q[k] <= '0;
			end
		end else if (wr_en && wr_type == REQ_LEVEL) begin
			lvl_q[wr_row[IW-1:0]] <= wr_level;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Row level captured alongside the memory read.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			vi_s1 <= lvl_q[cmd.row_idx[IW-1:0]];
		end
	end

	// Stage two: one level-by-weight product per column lane.
	always_ff @(posedge clk) begin
		vi_s2 <= vi_s1;
		for (int k = 0; k < DIM; k++) begin
			prod_s2[k] <= $signed({1'b0, lvl_q[k]}) *
				$signed(wrow_s1[k*WEIGHT_W +: WEIGHT_W]);
		end
	end

	// Pair sum, saturation and scaling by the row level, per word lane.
	always_comb begin
		for (int j = 0; j < WORDS; j++) begin
			pair_sum[j] = (PROD_W+1)'(prod_s2[2*j]) + (PROD_W+1)'(prod_s2[2*j+1]);
			mul_full[j] = {{LEVEL_W{1'b0}}, sat16(pair_sum[j])} *
				{{WORD_W{1'b0}}, vi_s2};
		end
	end

	// Stage three: the wrapped word terms.
	always_ff @(posedge clk) begin
		for (int j = 0; j < WORDS; j++) begin
			term_s3[j] <= mul_full[j][WORD_W-1:0];
		end
	end

	// Stage four: word accumulators, wrapping at the word width.
	always_ff @(posedge clk) begin
		for (int j = 0; j < WORDS; j++) begin
			if (cmd.clear_acc) begin
				acc_q[j] <= '0;
			end else if (valid_s3) begin
				acc_q[j] <= acc_q[j] + term_s3[j];
			end
		end
	end

	// Group sums of consecutive words, each wrapping at the word width.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_sum[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				grp_sum[g] = grp_sum[g] + acc_q[g*GROUP + j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.group_load) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_q[g] <= grp_sum[g];
			end
		end
	end

	// Exact sum of the signed group values.
	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + VALUE_W'($signed(grp_q[g]));
		end
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.total_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.total_load) begin
			out_value_q <= total;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_value     = out_value_q;
	assign stat.busy     = valid_s1 | valid_s2 | valid_s3;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// ===== sv/int8_quadratic_form_eval.sv =====
// Top level of the int8 quadratic form evaluator: stream ports, controller and datapath.
//
// The block computes a grouped, wrapped v^T M v over a 32x32 signed 8-bit matrix and a
// vector of 32 unsigned 8-bit levels. Each input beat writes one matrix weight
// (tuser = 0) or one level (tuser = 1); load beats can follow back to back. A level
// beat with tlast set stores the level and then starts an evaluation, during which no
// input beat is taken. The weights sit in a memory of 32 rows of 256 bits with byte
// writes; the evaluation reads one row per cycle for the row walk, then drains the
// multiply pipeline until it is empty, then forms the group and final sums. The next
// input beat can be taken from the cycle in which the result becomes valid. If the
// previous result has not yet been taken, the final sum and the input both wait for
// it. The result waits in an output register; further load beats are taken while it
// waits. Weights that were never written give an undefined result.
`default_nettype none
`include "int8_quadratic_form_eval_defines.svh"

module int8_quadratic_form_eval #(
	parameter int DIM = qfe_pkg::QFE_DIM
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// row [4:0], col [9:5], weight [17:10], level [25:18], zero [31:26]
	input  wire logic [qfe_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type [0]
	input  wire logic                              s_tuser,
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// value [17:0], zero [23:18]
	output logic [qfe_pkg::OUT_DATA_W-1:0]         m_tdata
);
	import qfe_pkg::*;

	localparam int COL_LO    = ROW_W;
	localparam int WEIGHT_LO = COL_LO + COL_W;
	localparam int LEVEL_LO  = WEIGHT_LO + WEIGHT_W;

	qfe_cmd_t  cmd;
	qfe_stat_t stat;
	logic      in_fire;
	logic      eval_beat;
	logic signed [VALUE_W-1:0] value;

	// Input beat decode.
	assign in_fire   = s_tvalid && s_tready;
	assign eval_beat = (s_tuser == REQ_LEVEL) && s_tlast;

	qfe_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_eval  (eval_beat),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	qfe_dpath #(
		.DIM(DIM)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_fire),
		.wr_type   (s_tuser),
		.wr_row    (s_tdata[COL_LO-1:0]),
		.wr_col    (s_tdata[WEIGHT_LO-1:COL_LO]),
		.wr_weight (s_tdata[LEVEL_LO-1:WEIGHT_LO]),
		.wr_level  (s_tdata[LEVEL_LO+LEVEL_W-1:LEVEL_LO]),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (value)
	);

	// Result beat packing.
	assign m_tdata = {{(OUT_DATA_W-VALUE_W){1'b0}}, value};

	// Checks on the sequencing.
	`QFE_ASSERT_NEXT(a_eval_stops_input, clk, arst_n, in_fire && eval_beat, !s_tready, "input taken after an evaluation start")
	`QFE_ASSERT_NOW(a_issue_blocks_input, clk, arst_n, cmd.issue, !s_tready, "input ready during the row walk")
	`QFE_ASSERT_NOW(a_walk_starts_row0, clk, arst_n, $rose(cmd.issue), cmd.row_idx == '0, "row walk did not start at row zero")
	`QFE_ASSERT_NOW(a_result_not_lost, clk, arst_n, cmd.total_load, !m_tvalid || m_tready, "result overwritten before it was taken")

endmodule

`default_nettype wire
